/* rtl/cht_pkg.sv */
// Shared types and constants for the chained hash table.
package cht_pkg;

  localparam int KEY_W       = 31;
  localparam int CFG_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int BUCKET_W    = 4;
  localparam int POSITION_W  = 7;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(10);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 2'd0,
    RES_FOUND     = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_FULL      = 2'd3
  } res_status_e;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_ONE,
    POS_WALK
  } pos_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic        load;
    logic        ins_slot;
    logic        ins_node;
    logic        walk_start;
    logic        walk_next;
    logic        emit;
    res_status_e res_status;
    pos_sel_e    pos_sel;
  } cht_cmd_t;

  typedef struct packed {
    logic op_search;
    logic rem_done;
    logic slot_used;
    logic slot_match;
    logic slot_link_ok;
    logic pool_full;
    logic node_match;
    logic node_link_ok;
    logic pos_ok;
  } cht_sts_t;

endpackage

/* rtl/cht_rem.sv */
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
module cht_rem #(
  parameter int DW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cht_pkg::KEY_W-1:0] dividend_i,
  input  logic [DW-1:0]             divisor_i,
  output logic                      done_o,
  output logic [DW-1:0]             rem_o
);

  localparam int CW = $clog2(cht_pkg::KEY_W);

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [cht_pkg::KEY_W-1:0] shift_q, shift_d;
  logic [DW-1:0]             rem_q, rem_d;
  logic [DW:0]               trial;

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    trial   = {rem_q, shift_q[cht_pkg::KEY_W-1]};
    if (start_i) begin
      run_d   = 1'b1;
      cnt_d   = CW'(cht_pkg::KEY_W - 1);
      shift_d = dividend_i;
      rem_d   = '0;
    end else if (run_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = DW'(trial);
      end
      shift_d = shift_q << 1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/cht_ctrl.sv */
// Request sequencer: hash, slot check, chain walk and result issue.
module cht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cht_pkg::cht_sts_t sts_i,
  output cht_pkg::cht_cmd_t cmd_o,
  output logic              busy_o
);

  cht_pkg::state_e   state_q, state_d;
  cht_pkg::cht_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd            = '0;
    cmd.res_status = cht_pkg::RES_NOT_FOUND;
    cmd.pos_sel    = cht_pkg::POS_ZERO;
    case (state_q)
      cht_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = cht_pkg::ST_DIV;
        end
      end
      cht_pkg::ST_DIV: begin
        if (sts_i.rem_done) begin
          state_d = cht_pkg::ST_SLOT_RD;
        end
      end
      cht_pkg::ST_SLOT_RD: begin
        state_d = cht_pkg::ST_SLOT_CHK;
      end
      cht_pkg::ST_SLOT_CHK: begin
        state_d  = cht_pkg::ST_IDLE;
        cmd.emit = 1'b1;
        if (!sts_i.op_search) begin
          if (!sts_i.slot_used) begin
            cmd.ins_slot   = 1'b1;
            cmd.res_status = cht_pkg::RES_INSERTED;
          end else if (sts_i.pool_full) begin
            cmd.res_status = cht_pkg::RES_FULL;
          end else begin
            cmd.ins_node   = 1'b1;
            cmd.res_status = cht_pkg::RES_INSERTED;
            cmd.pos_sel    = cht_pkg::POS_ONE;
          end
        end else if (sts_i.slot_used && sts_i.slot_match) begin
          cmd.res_status = cht_pkg::RES_FOUND;
        end else if (sts_i.slot_used && sts_i.slot_link_ok) begin
          cmd.emit       = 1'b0;
          cmd.walk_start = 1'b1;
          state_d        = cht_pkg::ST_WALK;
        end
      end
      cht_pkg::ST_WALK: begin
        if (sts_i.node_match) begin
          cmd.emit       = 1'b1;
          cmd.res_status = cht_pkg::RES_FOUND;
          cmd.pos_sel    = cht_pkg::POS_WALK;
          state_d        = cht_pkg::ST_IDLE;
        end else if (sts_i.node_link_ok && sts_i.pos_ok) begin
          cmd.walk_next = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          state_d  = cht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cht_pkg::ST_IDLE;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != cht_pkg::ST_IDLE);

endmodule

/* rtl/cht_dp.sv */
// Datapath: bucket count register, slot and node stores, walk counter, result registers.
module cht_dp #(
  parameter int MAX_BUCKETS = 16,
  parameter int POOL_NODES  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         operation_i,
  input  logic [cht_pkg::KEY_W-1:0]    key_i,
  input  cht_pkg::cht_cmd_t            cmd_i,
  output cht_pkg::cht_sts_t            sts_o,
  output logic                         result_valid_o,
  output logic [cht_pkg::STATUS_W-1:0] status_o,
  output logic [cht_pkg::BUCKET_W-1:0] bucket_o,
  output logic [cht_pkg::POSITION_W-1:0] position_o
);

  localparam int DW = $clog2(MAX_BUCKETS + 1);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [NW-1:0] NO_LINK = NW'(POOL_NODES);

  logic [cht_pkg::CFG_W-1:0] bucket_count_q;
  logic                      op_q;
  logic [cht_pkg::KEY_W-1:0] key_q;
  logic [DW-1:0]             divisor;
  logic                      rem_done;
  logic [DW-1:0]             rem;
  logic [BW-1:0]             bidx;

  logic [MAX_BUCKETS-1:0]    slot_used_q;
  logic [cht_pkg::KEY_W-1:0] slot_key_mem [MAX_BUCKETS];
  logic [NW-1:0]             slot_link_mem [MAX_BUCKETS];
  logic [cht_pkg::KEY_W-1:0] slot_key_rd_q;
  logic [NW-1:0]             slot_link_rd_q;

  logic [cht_pkg::KEY_W-1:0] node_key_mem [POOL_NODES];
  logic [NW-1:0]             node_link_mem [POOL_NODES];
  logic [cht_pkg::KEY_W-1:0] node_key_rd_q;
  logic [NW-1:0]             node_link_rd_q;
  logic [AW-1:0]             node_raddr;
  logic                      node_re;

  logic [NW-1:0]             taken_q;
  logic [NW-1:0]             pos_q;

  logic                      res_valid_q;
  logic [cht_pkg::STATUS_W-1:0]   res_status_q;
  logic [cht_pkg::BUCKET_W-1:0]   res_bucket_q;
  logic [cht_pkg::POSITION_W-1:0] res_pos_d, res_pos_q;

  // Clamp the configured count into one through MAX_BUCKETS.
  always_comb begin
    if (bucket_count_q == '0) begin
      divisor = DW'(1);
    end else if (32'(bucket_count_q) > MAX_BUCKETS) begin
      divisor = DW'(MAX_BUCKETS);
    end else begin
      divisor = DW'(bucket_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= cht_pkg::BUCKET_COUNT_RST;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
  end

  cht_rem #(
    .DW (DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (key_i),
    .divisor_i  (divisor),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign bidx = rem[BW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= '0;
      taken_q     <= '0;
    end else begin
      if (cmd_i.ins_slot) begin
        slot_used_q[bidx] <= 1'b1;
      end
      if (cmd_i.ins_node) begin
        taken_q <= taken_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_slot) begin
      slot_key_mem[bidx] <= key_q;
    end
    if (cmd_i.ins_slot) begin
      slot_link_mem[bidx] <= NO_LINK;
    end else if (cmd_i.ins_node) begin
      slot_link_mem[bidx] <= taken_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_key_rd_q  <= slot_key_mem[bidx];
    slot_link_rd_q <= slot_link_mem[bidx];
  end

  assign node_re    = cmd_i.walk_start | cmd_i.walk_next;
  assign node_raddr = cmd_i.walk_start ? slot_link_rd_q[AW-1:0] : node_link_rd_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_node) begin
      node_key_mem[taken_q[AW-1:0]]  <= key_q;
      node_link_mem[taken_q[AW-1:0]] <= slot_link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_re) begin
      node_key_rd_q  <= node_key_mem[node_raddr];
      node_link_rd_q <= node_link_mem[node_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      pos_q <= NW'(1);
    end else if (cmd_i.walk_next) begin
      pos_q <= pos_q + NW'(1);
    end
  end

  always_comb begin
    case (cmd_i.pos_sel)
      cht_pkg::POS_ZERO: res_pos_d = '0;
      cht_pkg::POS_ONE:  res_pos_d = cht_pkg::POSITION_W'(1);
      cht_pkg::POS_WALK: res_pos_d = cht_pkg::POSITION_W'(pos_q);
      default:           res_pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_status_q <= cmd_i.res_status;
      res_bucket_q <= cht_pkg::BUCKET_W'(bidx);
      res_pos_q    <= res_pos_d;
    end
  end

  assign sts_o.op_search    = (op_q == cht_pkg::OP_SEARCH);
  assign sts_o.rem_done     = rem_done;
  assign sts_o.slot_used    = slot_used_q[bidx];
  assign sts_o.slot_match   = (slot_key_rd_q == key_q);
  assign sts_o.slot_link_ok = (32'(slot_link_rd_q) < POOL_NODES);
  assign sts_o.pool_full    = (32'(taken_q) >= POOL_NODES);
  assign sts_o.node_match   = (node_key_rd_q == key_q);
  assign sts_o.node_link_ok = (32'(node_link_rd_q) < POOL_NODES);
  assign sts_o.pos_ok       = (32'(pos_q) < POOL_NODES);

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign bucket_o       = res_bucket_q;
  assign position_o     = res_pos_q;

endmodule

/* rtl/chained_hash_table.sv */
// Top level of the chained hash table: controller and datapath.
//
// Requests: drive operation_i (0 insert, 1 search) and key_i and raise start;
// the request is taken at a clock edge where start is high and busy is low.
// Results: result_valid_o is high for exactly one cycle with status_o,
// bucket_o and position_o; the receiver cannot hold it off.
// Bucket count: cfg_we_i writes cfg_wdata_i at the clock edge; write it only
// while busy is low and no result is pending.
// Sequence: the bucket is found by a bit-serial remainder unit, one key bit
// per cycle, over all key bits; then the bucket slot is read and checked,
// and an insert, or a search that ends at the bucket slot, registers its
// result. A search that walks the chain reads one node at a time from the
// node store, at most POOL_NODES nodes. One request is in flight at a time;
// busy drops in the cycle the result is shown, and the next request can be taken then.
// Reset: the bucket count returns to 10, all bucket slots read as empty and
// the node pool is empty again; no clearing pass is needed.
module chained_hash_table #(
  parameter int MAX_BUCKETS = 16,
  parameter int POOL_NODES  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [cht_pkg::KEY_W-1:0]      key_i,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [cht_pkg::STATUS_W-1:0]   status_o,
  output logic [cht_pkg::BUCKET_W-1:0]   bucket_o,
  output logic [cht_pkg::POSITION_W-1:0] position_o
);

  cht_pkg::cht_cmd_t cmd;
  cht_pkg::cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  cht_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_NODES  (POOL_NODES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .bucket_o       (bucket_o),
    .position_o     (position_o)
  );

endmodule

/* rtl/cht_checker.sv */
// Port-level checks for the chained hash table, bound to the top level.
module cht_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           result_valid_o,
  input logic [cht_pkg::STATUS_W-1:0]   status_o,
  input logic [cht_pkg::POSITION_W-1:0] position_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without busy rising");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == cht_pkg::RES_NOT_FOUND ||
                        status_o == cht_pkg::RES_FULL)) |-> (position_o == '0))
    else $error("nonzero position on a miss or full result");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .position_o     (position_o)
);
